FILE: hw/rtl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants for the differential-drive PID core.
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int ACC_WIDTH_DEF = 32;   // default correction accumulator width
  localparam int DATA_W        = 16;   // error, gains, speeds, time step
  localparam int SUM_W         = 32;   // integral register
  localparam int MPLR_W        = 17;   // multiplier operand, one bit per cycle
  localparam int QUO_W         = 32;   // (diff << 16) / dt
  localparam int CFG_IDX_W     = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_KP   = 3'd0;
  localparam cfg_idx_t REG_KI   = 3'd1;
  localparam cfg_idx_t REG_KD   = 3'd2;
  localparam cfg_idx_t REG_BASE = 3'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] position_error;
    logic        [DATA_W-1:0] time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_cmd;
    logic signed [DATA_W-1:0] right_cmd;
    logic                     left_clamped;
    logic                     right_clamped;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM_RUN,
    S_P_RUN,
    S_I_RUN,
    S_D_WAIT,
    S_D_RUN,
    S_ADD,
    S_OUT
  } state_t;

endpackage

FILE: hw/rtl/pid_differential_drive_core.sv
// ----------------------------------------------------------------------------
// pid_differential_drive_core
// Line-following PID controller: correction P + I + D steers two motors.
// ----------------------------------------------------------------------------
// Flow: one word at a time; a new input word is taken only after the result
//   word of the last one has been loaded into the output register. The pace
//   is set by the shared 17-step shift-add multiplier, used four times.
//   The 32-step divider for the derivative runs alongside and is hidden.
// Reset: synchronous rst clears gains, base speed, last error and integral to
//   zero and empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_differential_drive_core #(
  parameter int ACC_WIDTH = pdd_pkg::ACC_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pdd_pkg::in_word_t         in_data,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output pdd_pkg::out_word_t        out_data,
  // register write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  pdd_pkg::cfg_idx_t         cfg_index,
  input  logic [pdd_pkg::DATA_W-1:0] cfg_data
);

  import pdd_pkg::*;

  // multiplicand must hold the integral and a saturated derivative quotient
  localparam int MW  = (ACC_WIDTH > SUM_W) ? ACC_WIDTH : SUM_W;
  localparam int XW  = MW + MPLR_W;     // full product width
  localparam int SW1 = SUM_W + 1;
  localparam int AW1 = ACC_WIDTH + 1;
  localparam int DW1 = DATA_W + 1;

  // saturate a wide signed value to the accumulator width
  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
    input logic signed [XW-1:0] x
  );
    logic same;
    same = (x[XW-1:ACC_WIDTH-1] == {(XW-ACC_WIDTH+1){x[XW-1]}});
    if (same) begin
      return x[ACC_WIDTH-1:0];
    end else if (x[XW-1]) begin
      return {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  endfunction

  // ---- configuration registers --------------------------------------------
  logic signed [DATA_W-1:0] gain_p;
  logic signed [DATA_W-1:0] gain_i;
  logic signed [DATA_W-1:0] gain_d;
  logic signed [DATA_W-1:0] base_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p   <= '0;
      gain_i   <= '0;
      gain_d   <= '0;
      base_cmd <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KP:   gain_p   <= cfg_data;
        REG_KI:   gain_i   <= cfg_data;
        REG_KD:   gain_d   <= cfg_data;
        REG_BASE: base_cmd <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---- datapath state ---------------------------------------------------------
  state_t state, state_next;

  logic signed [DATA_W-1:0]    last_error;
  logic signed [SUM_W-1:0]     error_sum;
  logic signed [DATA_W-1:0]    err_q;        // error of the word in flight
  logic                        div_neg;      // sign of the error difference
  logic signed [ACC_WIDTH-1:0] p_term;
  logic signed [ACC_WIDTH-1:0] i_term;
  logic signed [ACC_WIDTH-1:0] d_term;
  logic signed [ACC_WIDTH-1:0] corr;

  // ---- shared serial multiplier -----------------------------------------------
  logic                     mul_start;
  logic signed [MW-1:0]     mul_mcand;
  logic signed [MPLR_W-1:0] mul_mplier;
  logic                     mul_busy;
  logic                     mul_done;
  logic signed [XW-1:0]     mul_prod;

  pdd_mul_serial #(
    .MC_W (MW),
    .MP_W (MPLR_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_prod)
  );

  // ---- serial divider for the derivative quotient ---------------------------
  logic                    div_start;
  logic [QUO_W-1:0]        div_num;
  logic [DATA_W-1:0]       div_den;
  logic                    div_busy;
  logic [QUO_W-1:0]        div_quo;
  logic signed [DW1-1:0]   err_diff;
  logic [DATA_W-1:0]       diff_mag;
  logic [DATA_W-1:0]       dt_fix;

  // a zero step counts as the smallest step
  assign dt_fix   = (in_data.time_step == '0) ? DATA_W'(1) : in_data.time_step;
  assign err_diff = DW1'(in_data.position_error) - DW1'(last_error);
  assign diff_mag = err_diff[DW1-1] ? DATA_W'(-err_diff) : DATA_W'(err_diff);
  assign div_num  = {diff_mag, {(QUO_W-DATA_W){1'b0}}};   // |diff| * 2^16
  assign div_den  = dt_fix;

  pdd_div_serial #(
    .NUM_W (QUO_W),
    .DEN_W (DATA_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // quotient truncates toward zero: divide magnitudes, then restore the sign
  logic signed [XW-1:0]        q_full;
  logic signed [ACC_WIDTH-1:0] q_sat;

  assign q_full = div_neg ? -$signed(XW'(div_quo)) : $signed(XW'(div_quo));
  assign q_sat  = sat_acc(q_full);

  // ---- integral update: sat32(sum + floor(e*dt / 2^15)) ----------------------
  logic signed [SW1-1:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  assign sum_wide = SW1'(error_sum) + SW1'(mul_prod >>> 15);
  always_comb begin
    if (sum_wide[SW1-1] == sum_wide[SW1-2]) begin
      sum_sat = sum_wide[SUM_W-1:0];
    end else if (sum_wide[SW1-1]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  // ---- sequencer ----------------------------------------------------------------
  // Order: e*dt -> integral, Kp*e, Ki*sum, Kd*q (waits for the divider).
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          mul_start  = 1'b1;
          mul_mcand  = MW'(in_data.position_error);
          mul_mplier = {1'b0, dt_fix};
          div_start  = 1'b1;
          state_next = S_SUM_RUN;
        end
      end
      S_SUM_RUN: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mcand  = MW'(err_q);
          mul_mplier = MPLR_W'(gain_p);
          state_next = S_P_RUN;
        end
      end
      S_P_RUN: begin
        if (mul_done) begin
          // error_sum already holds this tick's update
          mul_start  = 1'b1;
          mul_mcand  = MW'(error_sum);
          mul_mplier = MPLR_W'(gain_i);
          state_next = S_I_RUN;
        end
      end
      S_I_RUN: begin
        if (mul_done) begin
          if (!div_busy) begin
            mul_start  = 1'b1;
            mul_mcand  = MW'(q_sat);
            mul_mplier = MPLR_W'(gain_d);
            state_next = S_D_RUN;
          end else begin
            state_next = S_D_WAIT;
          end
        end
      end
      S_D_WAIT: begin
        if (!div_busy) begin
          mul_start  = 1'b1;
          mul_mcand  = MW'(q_sat);
          mul_mplier = MPLR_W'(gain_d);
          state_next = S_D_RUN;
        end
      end
      S_D_RUN: begin
        if (mul_done) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // ---- term capture -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        last_error <= in_data.position_error;
      end
      if (state == S_SUM_RUN && mul_done) begin
        error_sum <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      err_q   <= in_data.position_error;
      div_neg <= err_diff[DW1-1];
    end
    if (state == S_P_RUN && mul_done) begin
      p_term <= sat_acc(mul_prod >>> 8);
    end
    if (state == S_I_RUN && mul_done) begin
      i_term <= sat_acc(mul_prod >>> 9);
    end
    if (state == S_D_RUN && mul_done) begin
      d_term <= sat_acc(mul_prod >>> 8);
    end
    if (state == S_ADD) begin
      corr <= sat_acc(XW'(p_term) + XW'(i_term) + XW'(d_term));
    end
  end

  // ---- motor mix and clamp ----------------------------------------------------
  logic signed [AW1-1:0]    left_w;
  logic signed [AW1-1:0]    right_w;
  logic signed [DATA_W-1:0] left_c;
  logic signed [DATA_W-1:0] right_c;
  logic                     left_hit;
  logic                     right_hit;

  assign left_w  = AW1'(base_cmd) + AW1'(corr);
  assign right_w = AW1'(base_cmd) - AW1'(corr);

  always_comb begin
    left_hit  = (left_w[AW1-1:DATA_W-1] != {(AW1-DATA_W+1){left_w[AW1-1]}});
    right_hit = (right_w[AW1-1:DATA_W-1] != {(AW1-DATA_W+1){right_w[AW1-1]}});
    if (!left_hit) begin
      left_c = left_w[DATA_W-1:0];
    end else if (left_w[AW1-1]) begin
      left_c = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      left_c = {1'b0, {(DATA_W-1){1'b1}}};
    end
    if (!right_hit) begin
      right_c = right_w[DATA_W-1:0];
    end else if (right_w[AW1-1]) begin
      right_c = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      right_c = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // ---- output register --------------------------------------------------------
  logic out_load;

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.left_cmd      <= left_c;
      out_data.right_cmd     <= right_c;
      out_data.left_clamped  <= left_hit;
      out_data.right_clamped <= right_hit;
    end
  end

  // ---- checks -----------------------------------------------------------------
  // the sequencer never restarts the multiplier mid-product
  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

  // a finished product only arrives while a multiply stage is waiting for it
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_SUM_RUN || state == S_P_RUN ||
                  state == S_I_RUN || state == S_D_RUN))
    else $error("product finished outside a multiply stage");

  // a waiting result word is never overwritten by the next one
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> $stable(out_data))
    else $error("pending result word overwritten");

endmodule

FILE: hw/rtl/pdd_mul_serial.sv
// ----------------------------------------------------------------------------
// pdd_mul_serial
// Signed shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pdd_mul_serial #(
  parameter int MC_W = 32,
  parameter int MP_W = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [MC_W-1:0]         mcand,
  input  logic signed [MP_W-1:0]         mplier,
  output logic                           busy,
  output logic                           done,
  output logic signed [MC_W+MP_W-1:0]    product
);

  localparam int PW    = MC_W + MP_W;
  localparam int CNT_W = $clog2(MP_W);

  logic signed [MC_W-1:0] mc;
  logic        [MP_W-1:0] mp;
  logic        [CNT_W-1:0] cnt;
  logic signed [PW-1:0]   addend;
  logic signed [PW-1:0]   product_next;

  // top bit of a two's complement multiplier weighs negative
  always_comb begin
    if (!mp[MP_W-1]) begin
      addend = '0;
    end else if (cnt == CNT_W'(MP_W-1)) begin
      addend = -PW'(mc);
    end else begin
      addend = PW'(mc);
    end
    product_next = (product <<< 1) + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MP_W-1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc      <= mcand;
      mp      <= mplier;
      product <= '0;
    end else if (busy) begin
      product <= product_next;
      mp      <= mp << 1;
    end
  end

endmodule

FILE: hw/rtl/pdd_div_serial.sv
// ----------------------------------------------------------------------------
// pdd_div_serial
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdd_div_serial #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,    // never zero
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] dv;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {rem, quotient[NUM_W-1]};
    trial_sub = trial - {1'b0, dv};
    fits      = (trial >= {1'b0, dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W-1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= num;
      dv       <= den;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

FILE: sim/tb_pid_differential_drive_core.sv
// ----------------------------------------------------------------------------
// tb_pid_differential_drive_core
// Self-checking bench for the differential-drive PID core. Error samples go
// in on a valid/ready channel; a scoreboard class keeps its own copy of the
// gains, the last error and the integral. For each accepted word it predicts
// both motor commands and their clamp flags. Each result word is checked,
// field by field, against the oldest prediction. Register settings move
// between the extremes and random values, changed only while the core is
// idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pid_differential_drive_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pdd_pkg::*;

  typedef logic [DATA_W-1:0] reg_word_t;

  localparam int        ACC_W        = ACC_WIDTH_DEF;
  localparam int        CLK_PERIOD   = 4;
  localparam int        RESET_CYCLES = 8;
  localparam int        MAX_IDLE     = 7;
  localparam int        DRAIN_CYCLES = 120;     // longer than one result latency
  localparam int        CYCLE_LIMIT  = 600000;  // above the slowest legal run
  localparam cfg_idx_t  REG_SPARE    = REG_BASE + 3'd1;  // first index with no register

  // Q8.8 gains and Q1.15 speeds used as fixed points of the sweep
  localparam reg_word_t GAIN_ONE     = 16'h0100;
  localparam reg_word_t GAIN_HALF    = 16'h0080;
  localparam reg_word_t GAIN_SIXTEEN = 16'h0010;
  localparam reg_word_t SPEED_HALF   = 16'h4000;
  localparam reg_word_t WORD_MAX     = 16'h7fff;
  localparam reg_word_t WORD_MIN     = 16'h8000;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts motor commands and holds them until they come out
  // --------------------------------------------------------------------------
  class motor_cmd_scoreboard;
    localparam longint ACC_MAX   = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
    localparam longint ACC_MIN   = -ACC_MAX - 1;
    localparam longint SUM_MAX   = 64'sd2147483647;
    localparam longint SUM_MIN   = -SUM_MAX - 1;
    localparam longint SPEED_MAX = 32767;
    localparam longint SPEED_MIN = -32768;

    logic signed [DATA_W-1:0] kp = '0;
    logic signed [DATA_W-1:0] ki = '0;
    logic signed [DATA_W-1:0] kd = '0;
    logic signed [DATA_W-1:0] base = '0;
    logic signed [DATA_W-1:0] prev_error = '0;
    logic signed [SUM_W-1:0]  integral = '0;

    out_word_t expected_cmds[$];
    int        mismatches = 0;
    int        cmds_checked = 0;
    int        samples_noted = 0;

    function longint clip(longint x, longint lo, longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    function void write_register(cfg_idx_t idx, reg_word_t value);
      case (idx)
        REG_KP:   kp = value;
        REG_KI:   ki = value;
        REG_KD:   kd = value;
        REG_BASE: base = value;
        default: ;
      endcase
    endfunction

    // one accepted error sample -> one predicted motor command
    function void note_error_sample(in_word_t w);
      longint    err;
      longint    dt;
      longint    p_term;
      longint    i_term;
      longint    slope;
      longint    d_term;
      longint    corr;
      longint    left;
      longint    right;
      longint    left_c;
      longint    right_c;
      out_word_t cmd;

      err = longint'(w.position_error);
      dt  = longint'(w.time_step);
      if (dt == 0) dt = 1;  // zero step counts as the shortest one

      // integral of error*dt in Q16.16, updated value used this tick
      integral = SUM_W'(clip(integral + ((err * dt) >>> 15), SUM_MIN, SUM_MAX));

      p_term = clip((longint'(kp) * err) >>> 8, ACC_MIN, ACC_MAX);
      i_term = clip((longint'(ki) * integral) >>> 9, ACC_MIN, ACC_MAX);
      slope  = clip(((err - prev_error) * 65536) / dt, ACC_MIN, ACC_MAX);
      d_term = clip((longint'(kd) * slope) >>> 8, ACC_MIN, ACC_MAX);
      corr   = clip(p_term + i_term + d_term, ACC_MIN, ACC_MAX);

      left    = base + corr;
      right   = base - corr;
      left_c  = clip(left, SPEED_MIN, SPEED_MAX);
      right_c = clip(right, SPEED_MIN, SPEED_MAX);

      prev_error = w.position_error;

      cmd.left_cmd      = left_c[DATA_W-1:0];
      cmd.right_cmd     = right_c[DATA_W-1:0];
      cmd.left_clamped  = (left_c != left);
      cmd.right_clamped = (right_c != right);
      expected_cmds.push_back(cmd);
      samples_noted++;
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t: cmd %0d: %s", $time, cmds_checked, what);
    endtask

    task check_motor_cmd(out_word_t got);
      out_word_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
      end else begin
        want = expected_cmds.pop_front();
        cmds_checked++;
        if (got.left_cmd !== want.left_cmd)
          report($sformatf("left_cmd %0d, want %0d", got.left_cmd, want.left_cmd));
        if (got.right_cmd !== want.right_cmd)
          report($sformatf("right_cmd %0d, want %0d", got.right_cmd, want.right_cmd));
        if (got.left_clamped !== want.left_clamped)
          report($sformatf("left_clamped %b, want %b", got.left_clamped, want.left_clamped));
        if (got.right_clamped !== want.right_clamped)
          report($sformatf("right_clamped %b, want %b", got.right_clamped,
                           want.right_clamped));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = REG_KP;
  reg_word_t cfg_data = '0;

  motor_cmd_scoreboard sb = new();

  bit              steady = 1'b0;        // no idling on either side while set
  logic [DATA_W-1:0] last_sent_error = '0; // anchor for slowly drifting errors
  int              settings_applied = 0;
  int unsigned     cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  pid_differential_drive_core #(
    .ACC_WIDTH (ACC_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int draw_idle();
    if (steady) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // Drive one error word and hold it until accepted. Valid is only dropped
  // when a gap is drawn, so back-to-back words never see a low/high pair.
  task automatic send_error_sample(input in_word_t w);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_error_sample(w);
  endtask

  task automatic send_pair(input reg_word_t err, input reg_word_t dt);
    in_word_t w;
    w.position_error = err;
    w.time_step      = dt;
    send_error_sample(w);
  endtask

  // Register write; valid stays up so the caller can chain writes
  task automatic write_reg(input cfg_idx_t idx, input reg_word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, value);
  endtask

  // Waits for the core to drain, then loads a full register set. Every
  // word yields a result, so an empty queue means the core is idle.
  // A stray write to an index past the register file rides along each time.
  task automatic program_drive(input reg_word_t kp, input reg_word_t ki,
                               input reg_word_t kd, input reg_word_t base);
    in_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_SPARE + cfg_idx_t'($urandom_range(0, 3)), reg_word_t'($urandom));
    write_reg(REG_BASE, base);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  function automatic reg_word_t random_gain();
    if ($urandom_range(0, 2) == 0) return reg_word_t'($urandom);
    return reg_word_t'(int'($urandom_range(0, 1023)) - 512);  // within +/-2.0
  endfunction

  // Mostly a sensor trace drifting slowly, mixed with full-range noise,
  // extremes and near-centre values. Steps lean towards very short and
  // very long to push the derivative and the integral.
  function automatic in_word_t random_sample();
    in_word_t w;
    case ($urandom_range(0, 9))
      0:       w.position_error = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      1, 2:    w.position_error = reg_word_t'(int'($urandom_range(0, 1023)) - 512);
      3, 4, 5: w.position_error = last_sent_error +
                                  reg_word_t'(int'($urandom_range(0, 255)) - 128);
      default: w.position_error = reg_word_t'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0, 1:    w.time_step = reg_word_t'($urandom_range(1, 16));
      2:       w.time_step = reg_word_t'($urandom_range(65000, 65535));
      default: w.time_step = reg_word_t'($urandom_range(1, 65535));
    endcase
    last_sent_error = w.position_error;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall per word, checked at the accepting edge
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_motor_cmd(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: all gains and base speed zero, commands must be zero
    send_pair(WORD_MAX, 16'hffff);
    send_pair(WORD_MIN, 16'h0001);

    // Directed: unit P, half I, small D, half base speed
    program_drive(GAIN_ONE, GAIN_HALF, GAIN_SIXTEEN, SPEED_HALF);
    send_pair(16'h0000, 16'h0001);
    send_pair(WORD_MAX, 16'hffff);   // left clamps high
    send_pair(WORD_MIN, 16'hffff);   // full swing over a long step
    send_pair(WORD_MIN, 16'h0001);   // no change, derivative zero
    send_pair(WORD_MAX, 16'h0001);   // full swing over the shortest step
    send_pair(WORD_MIN, 16'h0001);   // and back: derivative saturates low
    send_pair(16'h0001, 16'h0000);   // zero step taken as one
    send_pair(16'hffff, 16'h0000);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'h4000, 16'h0001);
    send_pair(16'h0000, 16'hffff);
    send_pair(16'hffff, 16'h0100);
    send_pair(16'h5555, 16'haaaa);
    send_pair(16'haaaa, 16'h5555);

    // All gains and base at the positive limit
    program_drive(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_pair(WORD_MAX, 16'h0000);   // zero step with the largest gains
    repeat (50) send_error_sample(random_sample());

    // All gains and base at the negative limit
    program_drive(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_pair(WORD_MIN, 16'hffff);
    repeat (50) send_error_sample(random_sample());

    // No correction at all: both commands follow the base speed
    steady = 1'b1;
    program_drive(16'h0000, 16'h0000, 16'h0000, reg_word_t'($urandom));
    repeat (30) send_error_sample(random_sample());

    // Random settings; roughly one phase in four runs without idling
    repeat (7) begin
      steady = ($urandom_range(0, 3) == 0);
      program_drive(random_gain(), random_gain(), random_gain(), reg_word_t'($urandom));
      repeat (55) send_error_sample(random_sample());
    end

    // Drain, then leave room for any stray result word
    steady = 1'b0;
    in_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d error samples under %0d register settings, gains at both limits.",
             sb.samples_noted, settings_applied);
    $display("Compared %0d motor commands, %0d mismatches.", sb.cmds_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
